>>> hw/rtl/fcbr_pkg.sv
package fcbr_pkg;

    // canvas side in pixels, one memory word holds one column
    localparam int CANVAS_SIZE = 256;
    localparam int ADDR_W      = $clog2(CANVAS_SIZE);

    // clipping limit min(active_size, CANVAS_SIZE) must hold CANVAS_SIZE itself
    localparam int LIM_W = ($clog2(CANVAS_SIZE + 1) > 9) ? $clog2(CANVAS_SIZE + 1) : 9;

    // signed working width for columns, rows and the decision term
    localparam int CRD_W = 14;

    localparam logic [8:0] ACTIVE_RESET = 9'd201;

    // register index taken from paddr[2]
    localparam logic REG_ACTIVE_SIZE = 1'b0;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef logic [CANVAS_SIZE-1:0] col_word_t;

    // one clipped vertical span waiting for its read-modify-write
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] col;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } span_t;

endpackage

>>> hw/rtl/filled_circle_bitmap_raster_core.sv
// Filled circle raster on a one-bit canvas of CANVAS_SIZE x CANVAS_SIZE pixels. A command is
// taken when start is high and busy is low; every command gives exactly one beat on done,
// one cycle wide, that the receiver must take as it comes (there is no way to hold it off).
// pixel_value carries the canvas bit for a read and is 0 for every other command. Clear
// and unused codes pass through ST_FIN to done, a read through ST_RD and ST_RDOUT. A draw
// runs the midpoint loop: one column span per cycle, except in the decision update, into a
// single column-wide memory (one read port, one write port); each loop iteration is one
// decision update plus four span states. The canvas has no clearing pass: one valid bit
// per column makes clear and reset take effect at once. active_size is written over the
// APB port at byte address 0, by the user only while idle; the block does not enforce it.
module filled_circle_bitmap_raster_core (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic signed [11:0] center_x,
    input  logic signed [11:0] center_y,
    input  logic [9:0]  circle_radius,
    // result channel
    output logic        done,
    output logic        pixel_value,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = fcbr_pkg::ADDR_W;
    localparam int CW = fcbr_pkg::CRD_W;
    localparam int NW = fcbr_pkg::CANVAS_SIZE;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CSPAN = 4'd1;
    localparam logic [3:0] ST_PPT   = 4'd2;
    localparam logic [3:0] ST_MPT   = 4'd3;
    localparam logic [3:0] ST_STEP  = 4'd4;
    localparam logic [3:0] ST_SP0   = 4'd5;
    localparam logic [3:0] ST_SP1   = 4'd6;
    localparam logic [3:0] ST_SP2   = 4'd7;
    localparam logic [3:0] ST_SP3   = 4'd8;
    localparam logic [3:0] ST_RD    = 4'd9;
    localparam logic [3:0] ST_RDOUT = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    // canvas memory, one word per column, bit index is the row
    fcbr_pkg::col_word_t canvas_mem [NW];

    logic [3:0]                state_reg, state_next;
    logic [8:0]                active_reg, active_next;
    logic signed [11:0]        cx_reg, cx_next;
    logic signed [11:0]        cy_reg, cy_next;
    logic signed [CW-1:0]      f_reg, f_next;
    logic [9:0]                x_reg, x_next;
    logic [9:0]                y_reg, y_next;
    fcbr_pkg::span_t           p1_reg, p1_next;
    logic                      fwd_vld_reg, fwd_vld_next;
    logic [AW-1:0]             fwd_col_reg, fwd_col_next;
    fcbr_pkg::col_word_t       fwd_data_reg, fwd_data_next;
    fcbr_pkg::col_word_t       rd_data_reg;
    logic [NW-1:0]             colv_reg, colv_next;
    logic                      done_reg, done_next;
    logic                      pix_reg, pix_next;

    logic                      accept;
    logic                      cfg_wr;
    logic [fcbr_pkg::LIM_W-1:0] lim;
    logic signed [CW-1:0]      lim_s, lim_m1;
    logic signed [CW-1:0]      ext_cx, ext_cy, ext_x, ext_y;

    // span issue
    logic                      iss_on;
    logic signed [CW-1:0]      iss_col, iss_h, iss_lo, iss_hi;
    logic                      in_col, in_row;
    logic [AW-1:0]             lo_c, hi_c;

    // memory ports
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    fcbr_pkg::col_word_t       base_word, span_mask, wr_data;

    // decision update
    logic [9:0]                y_dec, x_inc;
    logic signed [CW-1:0]      f_mid, f_step;

    // read command
    logic                      rd_inside;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign pixel_value = pix_reg;

    // apb: always ready, one register at index 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == fcbr_pkg::REG_ACTIVE_SIZE) ? {23'd0, active_reg} : 32'd0;

    always_comb
    begin
        active_next = active_reg;
        if (cfg_wr && (paddr[2] == fcbr_pkg::REG_ACTIVE_SIZE))
        begin
            active_next = pwdata[8:0];
        end
    end

    // clipping square side
    always_comb
    begin
        if (fcbr_pkg::LIM_W'(active_reg) > fcbr_pkg::LIM_W'(NW))
        begin
            lim = fcbr_pkg::LIM_W'(NW);
        end
        else
        begin
            lim = fcbr_pkg::LIM_W'(active_reg);
        end
    end

    assign lim_s  = CW'(lim);
    assign lim_m1 = lim_s - CW'(1);

    assign ext_cx = CW'(cx_reg);
    assign ext_cy = CW'(cy_reg);
    assign ext_x  = CW'(x_reg);
    assign ext_y  = CW'(y_reg);

    // pick the span this state issues: column and half-height around the centre row
    always_comb
    begin
        iss_on  = 1'b1;
        iss_col = ext_cx;
        iss_h   = '0;
        case (state_reg)
            ST_CSPAN:
            begin
                iss_h = ext_y;
            end
            ST_PPT:  iss_col = ext_cx + ext_y;
            ST_MPT:  iss_col = ext_cx - ext_y;
            ST_SP0:
            begin
                iss_col = ext_cx + ext_x;
                iss_h   = ext_y;
            end
            ST_SP1:
            begin
                iss_col = ext_cx - ext_x;
                iss_h   = ext_y;
            end
            ST_SP2:
            begin
                iss_col = ext_cx + ext_y;
                iss_h   = ext_x;
            end
            ST_SP3:
            begin
                iss_col = ext_cx - ext_y;
                iss_h   = ext_x;
            end
            default: iss_on = 1'b0;
        endcase
    end

    // clip the span to the active square
    assign iss_lo = ext_cy - iss_h;
    assign iss_hi = ext_cy + iss_h;
    assign in_col = (iss_col >= 0) && (iss_col < lim_s);
    assign in_row = (iss_hi >= 0) && (iss_lo < lim_s);
    assign lo_c   = (iss_lo < 0) ? '0 : iss_lo[AW-1:0];
    assign hi_c   = (iss_hi >= lim_s) ? lim_m1[AW-1:0] : iss_hi[AW-1:0];

    always_comb
    begin
        p1_next.vld = iss_on && in_col && in_row;
        p1_next.col = iss_col[AW-1:0];
        p1_next.lo  = lo_c;
        p1_next.hi  = hi_c;
    end

    // read port: span column while drawing, pixel column for a read
    always_comb
    begin
        if (state_reg == ST_RD)
        begin
            rd_en   = 1'b1;
            rd_addr = cx_reg[AW-1:0];
        end
        else
        begin
            rd_en   = p1_next.vld;
            rd_addr = iss_col[AW-1:0];
        end
    end

    // modify: forward the word written last cycle when the same column comes back
    always_comb
    begin
        if (fwd_vld_reg && (fwd_col_reg == p1_reg.col))
        begin
            base_word = fwd_data_reg;
        end
        else if (colv_reg[p1_reg.col])
        begin
            base_word = rd_data_reg;
        end
        else
        begin
            base_word = '0;
        end
        span_mask = ({NW{1'b1}} << p1_reg.lo)
                  & ({NW{1'b1}} >> (AW'(NW - 1) - p1_reg.hi));
        wr_data   = base_word | span_mask;
    end

    assign wr_en         = p1_reg.vld;
    assign fwd_vld_next  = wr_en;
    assign fwd_col_next  = p1_reg.col;
    assign fwd_data_next = wr_data;

    // column valid bits stand in for clearing the memory
    always_comb
    begin
        colv_next = colv_reg;
        if (accept && (cmd == fcbr_pkg::CMD_CLEAR))
        begin
            colv_next = '0;
        end
        else if (wr_en)
        begin
            colv_next[p1_reg.col] = 1'b1;
        end
    end

    // midpoint decision update
    assign y_dec  = y_reg - 10'd1;
    assign x_inc  = x_reg + 10'd1;
    assign f_mid  = (f_reg > 0) ? (f_reg - $signed({3'd0, y_dec, 1'b0})) : f_reg;
    assign f_step = f_mid + $signed({3'd0, x_inc, 1'b0}) + CW'(1);

    assign rd_inside = (ext_cx >= 0) && (ext_cx < lim_s) && (ext_cy >= 0) && (ext_cy < lim_s);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        f_next     = f_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        done_next  = 1'b0;
        pix_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cx_next = center_x;
                    cy_next = center_y;
                    case (cmd)
                        fcbr_pkg::CMD_DRAW:
                        begin
                            f_next     = CW'(1) - CW'(circle_radius);
                            x_next     = '0;
                            y_next     = circle_radius;
                            state_next = ST_CSPAN;
                        end
                        fcbr_pkg::CMD_READ: state_next = ST_RD;
                        default:            state_next = ST_FIN;
                    endcase
                end
            end
            ST_CSPAN: state_next = ST_PPT;
            ST_PPT:   state_next = ST_MPT;
            ST_MPT:   state_next = ST_STEP;
            ST_STEP:
            begin
                if (x_reg < y_reg)
                begin
                    f_next     = f_step;
                    x_next     = x_inc;
                    y_next     = (f_reg > 0) ? y_dec : y_reg;
                    state_next = ST_SP0;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SP0:   state_next = ST_SP1;
            ST_SP1:   state_next = ST_SP2;
            ST_SP2:   state_next = ST_SP3;
            ST_SP3:   state_next = ST_STEP;
            ST_RD:    state_next = ST_RDOUT;
            ST_RDOUT:
            begin
                pix_next   = rd_inside && colv_reg[cx_reg[AW-1:0]]
                           && rd_data_reg[cy_reg[AW-1:0]];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // canvas memory: registered read, write from the modify stage
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= canvas_mem[rd_addr];
        end
        if (wr_en)
        begin
            canvas_mem[p1_reg.col] <= wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        f_reg        <= f_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        fwd_col_reg  <= fwd_col_next;
        fwd_data_reg <= fwd_data_next;
        pix_reg      <= pix_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= fcbr_pkg::ACTIVE_RESET;
            p1_reg      <= '0;
            fwd_vld_reg <= 1'b0;
            colv_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            p1_reg      <= p1_next;
            fwd_vld_reg <= fwd_vld_next;
            colv_reg    <= colv_next;
            done_reg    <= done_next;
        end
    end

endmodule

>>> hw/rtl/fcbr_checker.sv
module fcbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  cmd,
    input logic        done,
    input logic        pixel_value
);

    logic acc;

    assign acc = start && !busy;

    // a taken command holds the channel: busy is high in the cycle after the beat
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> busy)
        else $error("busy low right after a command beat");

    // a clear is answered, through the finish state, by a done beat with a zero pixel
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (cmd == fcbr_pkg::CMD_CLEAR)) |=> ##1 (done && !pixel_value))
        else $error("clear result missing or nonzero");

    // a read is answered by a done beat after the ST_RD and ST_RDOUT states
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (cmd == fcbr_pkg::CMD_READ)) |=> ##2 done)
        else $error("read result not on time");

    // a set pixel only shows on a result beat, and then the block is free
    a_pix_done: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_value |-> (done && !busy))
        else $error("pixel_value outside a result beat");

endmodule

bind filled_circle_bitmap_raster_core fcbr_checker u_fcbr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .pixel_value (pixel_value)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    // code the block must ignore, result reads 0
    localparam logic [1:0] CMD_NONE = 2'd3;
    // active_size is register 0, index sits in paddr[2]
    localparam logic [2:0] ACTIVE_SIZE_ADDR = {fcbr_pkg::REG_ACTIVE_SIZE, 2'b00};

    // one command beat as the sender sees it
    typedef struct {
        logic [1:0]        op;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [9:0]        rad;
    } cmd_item_t;

    // one expected result beat, with the command kept for messages
    typedef struct {
        logic [1:0]        op;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic              pixel;
    } pixel_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        cmd = fcbr_pkg::CMD_CLEAR;
    logic signed [11:0] center_x = '0;
    logic signed [11:0] center_y = '0;
    logic [9:0]        circle_radius = '0;
    logic              done;
    logic              pixel_value;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // commands waiting for the driver, results waiting for the block
    cmd_item_t   queued_cmds[$];
    pixel_beat_t pending_pixels[$];
    cmd_item_t   next_cmd;
    pixel_beat_t due;

    // predictor state: one word per column, bit index is the row, cleared like reset
    logic [fcbr_pkg::CANVAS_SIZE-1:0] canvas_col [fcbr_pkg::CANVAS_SIZE] = '{default: '0};
    logic [8:0]                       active_px = fcbr_pkg::ACTIVE_RESET;

    int  idle_pct = 7;
    int  fail_count = 0;
    // set at a rising edge when the command beat on the bus was taken
    logic cmd_taken = 1'b0;

    // last circle drawn, so reads can probe its rim
    int last_cx = 100;
    int last_cy = 100;
    int last_rad = 10;

    filled_circle_bitmap_raster_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .center_x      (center_x),
        .center_y      (center_y),
        .circle_radius (circle_radius),
        .done          (done),
        .pixel_value   (pixel_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // side of the clipping square, capped at the canvas
    function automatic int clip_limit();
        return (active_px > fcbr_pkg::CANVAS_SIZE) ? fcbr_pkg::CANVAS_SIZE : int'(active_px);
    endfunction

    // vertical run of pixels in one column, clipped to the active square
    function automatic void fill_span(int col, int row0, int half);
        int lim;
        int lo;
        int hi;
        int r;
        lim = clip_limit();
        if (col < 0 || col >= lim)
            return;
        lo = row0 - half;
        hi = row0 + half;
        if (lo < 0)
            lo = 0;
        if (hi > lim - 1)
            hi = lim - 1;
        for (r = lo; r <= hi; r++)
            canvas_col[col][r] = 1'b1;
    endfunction

    // midpoint fill: centre column, two side points, then mirrored spans
    function automatic void raster_circle(int x0, int y0, int rad);
        int f;
        int ddx;
        int ddy;
        int x;
        int y;
        f   = 1 - rad;
        ddx = 0;
        ddy = -2 * rad;
        x   = 0;
        y   = rad;
        fill_span(x0, y0, rad);
        fill_span(x0 + rad, y0, 0);
        fill_span(x0 - rad, y0, 0);
        while (x < y) begin
            if (f > 0) begin
                y--;
                ddy += 2;
                f += ddy;
            end
            x++;
            ddx += 2;
            f += ddx + 1;
            fill_span(x0 + x, y0, y);
            fill_span(x0 - x, y0, y);
            fill_span(x0 + y, y0, x);
            fill_span(x0 - y, y0, x);
        end
    endfunction

    function automatic logic pixel_at(int c, int r);
        int lim;
        lim = clip_limit();
        if (c < 0 || c >= lim || r < 0 || r >= lim)
            return 1'b0;
        return canvas_col[c][r];
    endfunction

    // runs one accepted command on the canvas copy, returns its result beat
    function automatic pixel_beat_t apply_command(logic [1:0] op, logic signed [11:0] cx,
                                                  logic signed [11:0] cy, logic [9:0] rad);
        pixel_beat_t beat;
        beat.op    = op;
        beat.cx    = cx;
        beat.cy    = cy;
        beat.pixel = 1'b0;
        case (op)
            fcbr_pkg::CMD_CLEAR: foreach (canvas_col[c]) canvas_col[c] = '0;
            fcbr_pkg::CMD_DRAW:  raster_circle(int'(cx), int'(cy), int'(rad));
            fcbr_pkg::CMD_READ:  beat.pixel = pixel_at(int'(cx), int'(cy));
            default:   ;
        endcase
        return beat;
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic void queue_cmd(logic [1:0] op, int cx, int cy, int rad);
        cmd_item_t it;
        it.op  = op;
        it.cx  = 12'(cx);
        it.cy  = 12'(cy);
        it.rad = 10'(rad);
        queued_cmds.push_back(it);
    endfunction

    // mostly small circles over the canvas and reads around the last rim,
    // with a few huge radii and full-range coordinates as noise
    function automatic cmd_item_t rand_command();
        cmd_item_t it;
        int sel;
        int reach;
        sel    = $urandom_range(99);
        it.op  = fcbr_pkg::CMD_READ;
        it.cx  = 12'($urandom);
        it.cy  = 12'($urandom);
        it.rad = 10'($urandom);
        if (sel < 4) begin
            it.op = fcbr_pkg::CMD_CLEAR;
        end else if (sel < 7) begin
            it.op = CMD_NONE;
        end else if (sel < 37) begin
            it.op = fcbr_pkg::CMD_DRAW;
            sel = $urandom_range(99);
            if (sel >= 15)
                it.rad = 10'($urandom_range(0, 40));
            else if (sel >= 2)
                it.rad = 10'($urandom_range(0, 160));
            if ($urandom_range(9) != 0) begin
                it.cx = 12'(int'($urandom_range(0, 300)) - 20);
                it.cy = 12'(int'($urandom_range(0, 300)) - 20);
            end
            last_cx  = int'(it.cx);
            last_cy  = int'(it.cy);
            last_rad = int'(it.rad);
        end else begin
            sel   = $urandom_range(99);
            reach = last_rad + 2;
            if (sel < 75) begin
                it.cx = 12'(last_cx + int'($urandom_range(0, 2 * reach)) - reach);
                it.cy = 12'(last_cy + int'($urandom_range(0, 2 * reach)) - reach);
            end else if (sel < 95) begin
                it.cx = 12'(int'($urandom_range(0, 280)) - 10);
                it.cy = 12'(int'($urandom_range(0, 280)) - 10);
            end
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // driver: one command beat at a time, random gaps
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_taken) begin
            // hold the beat until the block takes it
        end else if (queued_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_cmd = queued_cmds.pop_front();
            start         <= 1'b1;
            cmd           <= next_cmd.op;
            center_x      <= next_cmd.cx;
            center_y      <= next_cmd.cy;
            circle_radius <= next_cmd.rad;
        end else begin
            // idle cycle, garbage on the fields
            start         <= 1'b0;
            cmd           <= 2'($urandom);
            center_x      <= 12'($urandom);
            center_y      <= 12'($urandom);
            circle_radius <= 10'($urandom);
        end
    end

    // ---------------------------------------------------------------
    // monitor: check done beats, predict accepted commands, track config
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            // compare first, a beat taken now cannot finish in the same edge
            if (done) begin
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: done beat with nothing expected, expected none, got pixel %b",
                             $time, pixel_value);
                end else begin
                    due = pending_pixels.pop_front();
                    if (pixel_value !== due.pixel) begin
                        fail_count++;
                        $display("%0t: pixel_value for cmd %0d at (%0d,%0d): expected %b, got %b",
                                 $time, due.op, due.cx, due.cy, due.pixel, pixel_value);
                    end
                end
            end
            if (start && !busy)
                pending_pixels.push_back(apply_command(cmd, center_x, center_y, circle_radius));
            if (psel && penable && pwrite && pready
                && paddr[2] == fcbr_pkg::REG_ACTIVE_SIZE)
                active_px = pwdata[8:0];
        end
        cmd_taken <= rst_n && start && !busy;
    end

    // ---------------------------------------------------------------
    // config access and phase control
    // ---------------------------------------------------------------

    // setup cycle then access cycle, waits out pready
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write with junk in the upper bits, then read it back
    task automatic set_active_size(logic [8:0] side);
        logic [31:0] rd;
        apb_access(1'b1, ACTIVE_SIZE_ADDR, {23'($urandom), side}, rd);
        apb_access(1'b0, ACTIVE_SIZE_ADDR, 32'($urandom), rd);
        if (rd[8:0] !== active_px) begin
            fail_count++;
            $display("%0t: active_size read back: expected %0d, got %0d",
                     $time, active_px, rd[8:0]);
        end
    endtask

    // sender holds off until every command is taken and answered
    task automatic settle();
        while (queued_cmds.size() != 0 || start || busy || pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int         n_items;
        logic [8:0] side;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset size of 201
        idle_pct = 7;
        queue_cmd(fcbr_pkg::CMD_READ, 0, 0, 0);              // fresh canvas reads 0
        queue_cmd(fcbr_pkg::CMD_DRAW, 100, 100, 0);          // zero radius, centre only
        queue_cmd(fcbr_pkg::CMD_READ, 100, 100, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 101, 100, 0);
        queue_cmd(fcbr_pkg::CMD_DRAW, 0, 0, 1023);           // covers the whole active square
        queue_cmd(fcbr_pkg::CMD_READ, 200, 200, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 201, 200, 0);          // just past the clip bound
        queue_cmd(fcbr_pkg::CMD_READ, 0, 200, 0);
        queue_cmd(fcbr_pkg::CMD_CLEAR, 0, 0, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 200, 200, 0);
        queue_cmd(CMD_NONE, -1, -1, 1023);                   // unused code, no effect
        queue_cmd(fcbr_pkg::CMD_DRAW, -2048, -2048, 1023);   // fully clipped, low corner
        queue_cmd(fcbr_pkg::CMD_DRAW, 2047, 2047, 1023);     // fully clipped, high corner
        queue_cmd(fcbr_pkg::CMD_READ, 0, 0, 0);
        queue_cmd(fcbr_pkg::CMD_DRAW, -5, 150, 30);          // left edge clipped
        queue_cmd(fcbr_pkg::CMD_READ, 0, 150, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 25, 150, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 26, 150, 0);
        queue_cmd(fcbr_pkg::CMD_READ, -1, 150, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 2047, -2048, 0);
        queue_cmd(fcbr_pkg::CMD_READ, -2048, 2047, 0);
        queue_cmd(fcbr_pkg::CMD_DRAW, 2047, 0, 1);
        queue_cmd(fcbr_pkg::CMD_DRAW, 198, 198, 5);          // corner clipped
        queue_cmd(fcbr_pkg::CMD_READ, 200, 200, 0);
        queue_cmd(fcbr_pkg::CMD_READ, 198, 203, 0);
        settle();

        // random phases, each with its own clip size; the canvas is kept
        // across phases so shrinking and growing the square is exercised
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin side = 9'd256; n_items = 300; end
                1:       begin side = 9'd0;   n_items = 80;  end
                2:       begin side = 9'd511; n_items = 250; end
                3:       begin side = 9'd1;   n_items = 80;  end
                4:       begin side = 9'($urandom_range(2, 255)); n_items = 300; end
                default: begin side = fcbr_pkg::ACTIVE_RESET; n_items = 200; end
            endcase
            idle_pct = (p < 2) ? 7 : (p < 4) ? 60 : 0;
            set_active_size(side);
            repeat (n_items) queued_cmds.push_back(rand_command());
            settle();
        end

        // catch any stray done beat
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
